### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Holds the operation and status codes, the cell command type and the
// default list depth used by the engine and its cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Largest supported list depth and the width of a length or index.
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DEPTH_MAX = 64;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned DATA_W    = 32;

  // Input operation codes.
  localparam logic [2:0] KIND_INS_START = 3'd0;
  localparam logic [2:0] KIND_INS_END   = 3'd1;
  localparam logic [2:0] KIND_INS_POS   = 3'd2;
  localparam logic [2:0] KIND_REM_START = 3'd3;
  localparam logic [2:0] KIND_REM_END   = 3'd4;
  localparam logic [2:0] KIND_REM_POS   = 3'd5;
  localparam logic [2:0] KIND_DUMP      = 3'd6;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e               op;
    logic [LEN_W-1:0]       pos;   // insert or remove position
    logic [LEN_W-1:0]       tail;  // index of the last stored value
    logic signed [DATA_W-1:0] data; // value being inserted
  } cell_cmd_t;

endpackage

### rtl/core/positional_list_engine.sv
// A non-dump transaction loads its result into the output register when it is
// accepted; a dump of N stored values gives N results.
// Throughput: one insert or remove per cycle while results are taken, since all
// cells shift in the same cycle; a dump holds the input while the chain rotates
// its head out through the output register, one value per cycle while results are taken.
// Reset (rst_ni, async, active low) empties the list and the output register.
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list built as a chain of cells
// Inserts and removes at the start, the end or a position, and dumps the
// stored values from head to tail.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [5:0]               position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic                     last_o,
  output logic [LEN_W-1:0]         length_o
);

  // Controller states.
  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  localparam logic [LEN_W-1:0] DepthLen = LEN_W'(DEPTH);

  logic                     state_d, state_q;
  logic [LEN_W-1:0]         len_d, len_q;
  logic [LEN_W-1:0]         cnt_d, cnt_q;
  logic                     out_valid_d, out_valid_q;
  logic                     out_load;
  logic [1:0]               status_d, status_q;
  logic signed [DATA_W-1:0] element_d, element_q;
  logic                     last_d, last_q;

  logic                     out_free, accept;
  logic                     list_full, list_empty;
  logic [LEN_W-1:0]         pos_ext, ins_pos, rem_pos, tail;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] cell_val [DEPTH];

  // --------------------------------------------------------------------------
  // Chain of cells. Cell 0 is the head of the list. Each cell sees its two
  // neighbors and the head value, which lets the chain open a gap, close a
  // gap or rotate the stored values by one place in one update of all cells.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_val, right_val;

    if (g == 0) begin : g_head
      assign left_val = value_i;
    end else begin : g_body
      assign left_val = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign right_val = cell_val[0];
    end else begin : g_mid
      assign right_val = cell_val[g+1];
    end

    ple_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g])
    );
  end

  // --------------------------------------------------------------------------
  // Handshake. The output register frees up when its result is taken, so a
  // new transaction can enter in the same cycle as the previous result leaves.
  // --------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign list_full  = (len_q == DepthLen);
  assign list_empty = (len_q == '0);
  assign tail       = len_q - LEN_W'(1);

  // Positions past the end are clamped: an insert appends at the tail and
  // a remove takes the tail.
  assign pos_ext = {1'b0, position_i};
  assign ins_pos = (pos_ext > len_q) ? len_q : pos_ext;
  assign rem_pos = (pos_ext > tail)  ? tail  : pos_ext;

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    status_d  = STATUS_OK;
    element_d = '0;
    last_d    = 1'b1;
    cmd.op    = CELL_HOLD;
    cmd.pos   = '0;
    cmd.tail  = tail;
    cmd.data  = value_i;

    if (accept) begin
      unique case (kind_i) inside
        KIND_INS_START, KIND_INS_END, KIND_INS_POS: begin
          out_load = 1'b1;
          if (list_full) begin
            status_d = STATUS_FULL;
          end else begin
            cmd.op  = CELL_INSERT;
            cmd.pos = (kind_i == KIND_INS_START) ? '0 :
                      (kind_i == KIND_INS_END)   ? len_q : ins_pos;
            len_d   = len_q + LEN_W'(1);
          end
        end
        KIND_REM_START, KIND_REM_END, KIND_REM_POS: begin
          out_load = 1'b1;
          if (list_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            cmd.op  = CELL_REMOVE;
            cmd.pos = (kind_i == KIND_REM_START) ? '0 :
                      (kind_i == KIND_REM_END)   ? tail : rem_pos;
            len_d   = tail;
          end
        end
        KIND_DUMP: begin
          if (list_empty) begin
            out_load = 1'b1;
            status_d = STATUS_EMPTY;
          end else begin
            state_d = StDump;
            cnt_d   = '0;
          end
        end
        default: begin
          // The unused code leaves the list as it is and reports success.
          out_load = 1'b1;
        end
      endcase
    end else if ((state_q == StDump) && out_free) begin
      // Emit the head and rotate it to the tail. After len_q steps every
      // value is back in its original cell.
      out_load  = 1'b1;
      element_d = cell_val[0];
      last_d    = (cnt_q == tail);
      cmd.op    = CELL_ROTATE;
      cnt_d     = cnt_q + LEN_W'(1);
      if (cnt_q == tail) begin
        state_d = StIdle;
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload carries the length after the operation.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      element_q <= element_d;
      last_q    <= last_d;
    end
  end

  logic [LEN_W-1:0] out_len_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_len_q <= len_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign length_o    = out_len_q;

endmodule

### rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list chain
// Holds a single value and updates it from itself, its left or right
// neighbor, the head of the chain or the inserted value.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] head_i,
  output logic signed [DATA_W-1:0] value_o
);

  localparam logic [LEN_W-1:0] Idx = LEN_W'(INDEX);

  logic signed [DATA_W-1:0] value_d, value_q;

  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (Idx == cmd_i.pos) begin
          value_d = cmd_i.data;
        end else if (Idx > cmd_i.pos) begin
          value_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (Idx >= cmd_i.pos) begin
          value_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (Idx == cmd_i.tail) begin
          value_d = head_i;
        end else if (Idx < cmd_i.tail) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### rtl/core/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches the result channel of the engine and is bound to its top level.
// ----------------------------------------------------------------------------
module ple_checker
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               status_o,
  input logic signed [DATA_W-1:0] element_o,
  input logic                     last_o,
  input logic [LEN_W-1:0]         length_o
);

  // A stalled result stays valid and keeps its element and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_o) && $stable(last_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= LEN_W'(DEPTH))
    else $error("reported length exceeds the list depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> length_o == '0 && last_o && element_o == '0)
    else $error("empty status with a non-empty result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> length_o == LEN_W'(DEPTH) && last_o)
    else $error("full status while the list has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == STATUS_OK && length_o != '0)
    else $error("a non-final result outside a dump");

endmodule

bind positional_list_engine ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .element_o   (element_o),
  .last_o      (last_o),
  .length_o    (length_o)
);
